// ----- rtl/atf_pkg.sv -----
// Shared types and constants for the ATA read/write task-file builder.
// No dependencies; used by the datapath, the divider, the checker and the testbench.
package atf_pkg;

  localparam int POS_W = 48;
  localparam int CNT_W = 17;
  localparam int TAG_W = 5;
  localparam int HEADS_W = 5;
  localparam int SPT_W = 8;
  localparam int TRACK_W = HEADS_W + SPT_W;
  localparam int CYL_W = 16;
  localparam int HEAD_W = 4;
  localparam int SEC_W = 8;
  localparam int CMD_W = 8;
  localparam int COUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_STEP_BITS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BY_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_48BIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT = 2'd3;

  localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;
  localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;

  localparam logic [POS_W:0] LBA28_LIMIT = 49'h000000fffffff;
  localparam logic [CNT_W-1:0] SHORT_MAX_COUNT = 17'h00100;
  localparam logic [CNT_W-1:0] LONG_MAX_COUNT = 17'h0ffff;

  typedef enum logic [2:0] {
    LAYOUT_QLBA48 = 3'd0,
    LAYOUT_LBA48 = 3'd1,
    LAYOUT_QLBA28 = 3'd2,
    LAYOUT_LBA28 = 3'd3,
    LAYOUT_CHS = 3'd4
  } layout_t;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_TRACK = 2'd2
  } err_t;

  // ATA opcodes
  localparam logic [CMD_W-1:0] OP_READ_SECT = 8'h20;
  localparam logic [CMD_W-1:0] OP_WRITE_SECT = 8'h30;
  localparam logic [CMD_W-1:0] OP_READ_DMA = 8'hC8;
  localparam logic [CMD_W-1:0] OP_WRITE_DMA = 8'hCA;
  localparam logic [CMD_W-1:0] OP_READ_SECT_EXT = 8'h24;
  localparam logic [CMD_W-1:0] OP_WRITE_SECT_EXT = 8'h34;
  localparam logic [CMD_W-1:0] OP_READ_DMA_EXT = 8'h25;
  localparam logic [CMD_W-1:0] OP_WRITE_DMA_EXT = 8'h35;
  localparam logic [CMD_W-1:0] OP_READ_DMA_Q = 8'hC7;
  localparam logic [CMD_W-1:0] OP_WRITE_DMA_Q = 8'hCC;
  localparam logic [CMD_W-1:0] OP_READ_DMA_Q_EXT = 8'h26;
  localparam logic [CMD_W-1:0] OP_WRITE_DMA_Q_EXT = 8'h36;

  typedef struct packed {
    err_t error_code;
    layout_t layout;
    logic [CMD_W-1:0] command_code;
    logic [COUT_W-1:0] count_out;
    logic [POS_W-1:0] block_address;
    logic [TAG_W-1:0] tag_out;
    logic chs_ok;
  } tf_t;

  typedef struct packed {
    tf_t tf;
    logic [SPT_W-1:0] spt;
  } side1_t;

  typedef struct packed {
    tf_t tf;
    logic [CYL_W-1:0] cyl;
  } side2_t;

endpackage

// ----- rtl/ata_rw_taskfile_builder.sv -----
// ATA read/write task-file builder: one request in, one task-file result out.
// Path: decode register, track divider, sectors-per-track divider, output register.
// Throughput: one transfer per cycle while out_stall is low; the CHS divider pipelines set the depth.
// Reset (rst_n low, synchronous) empties all stages and loads register defaults:
// block addressing on, 48-bit allowed, 16 heads, 63 sectors per track.
// Depends on atf_pkg and atf_div.
module ata_rw_taskfile_builder #(
  parameter int StepBits = atf_pkg::DIV_STEP_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [atf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [atf_pkg::POS_W-1:0]         in_start_block,
  input  logic [atf_pkg::CNT_W-1:0]         in_block_count,
  input  logic                              in_write_req,
  input  logic                              in_use_dma,
  input  logic                              in_queued,
  input  logic [atf_pkg::TAG_W-1:0]         in_queue_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_error_code,
  output logic [2:0]                        out_layout,
  output logic [atf_pkg::CMD_W-1:0]         out_command_code,
  output logic [atf_pkg::COUT_W-1:0]        out_count_out,
  output logic [atf_pkg::POS_W-1:0]         out_block_address,
  output logic [atf_pkg::TAG_W-1:0]         out_tag_out,
  output logic [atf_pkg::CYL_W-1:0]         out_cylinder,
  output logic [atf_pkg::HEAD_W-1:0]        out_head,
  output logic [atf_pkg::SEC_W-1:0]         out_sector
);
  import atf_pkg::*;

  localparam int Side1W = $bits(side1_t);
  localparam int Side2W = $bits(side2_t);

  // configuration registers
  logic               abb_r;
  logic               a48_r;
  logic [HEADS_W-1:0] heads_r;
  logic [SPT_W-1:0]   spt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abb_r <= 1'b1;
      a48_r <= 1'b1;
      heads_r <= HEADS_RESET;
      spt_r <= SPT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADDR_BY_BLOCK: abb_r <= cfg_data[0];
        CFG_ALLOW_48BIT:   a48_r <= cfg_data[0];
        CFG_HEADS:         heads_r <= cfg_data[HEADS_W-1:0];
        CFG_SPT:           spt_r <= cfg_data[SPT_W-1:0];
      endcase
    end
  end

  // stage A: layout decode, opcode select, track size
  logic                dec_v_r;
  side1_t              dec_r;
  logic [POS_W-1:0]    pos_r;
  logic [TRACK_W-1:0]  track_r;
  side1_t              dec_nxt;
  logic [TRACK_W-1:0]  track_nxt;
  logic                dec_rdy;
  logic                div1_in_stall;

  always_comb begin : p_decode
    logic need_long;
    logic over_short;
    tf_t  tf;
    need_long = a48_r &&
      (({1'b0, in_start_block} + (POS_W+1)'(in_block_count)) > LBA28_LIMIT ||
       in_block_count > SHORT_MAX_COUNT);
    over_short = in_block_count > SHORT_MAX_COUNT;
    tf.error_code = ERR_OK;
    tf.layout = LAYOUT_CHS;
    tf.command_code = '0;
    tf.count_out = {8'h00, in_block_count[7:0]};
    tf.block_address = '0;
    tf.tag_out = '0;
    tf.chs_ok = 1'b0;
    if (abb_r) begin
      if (need_long) begin
        tf.layout = in_queued ? LAYOUT_QLBA48 : LAYOUT_LBA48;
        tf.error_code = (in_block_count > LONG_MAX_COUNT) ? ERR_LENGTH : ERR_OK;
        tf.count_out = in_block_count[COUT_W-1:0];
        tf.block_address = in_start_block;
        if (in_queued) begin
          tf.tag_out = in_queue_tag;
          tf.command_code = in_write_req ? OP_WRITE_DMA_Q_EXT : OP_READ_DMA_Q_EXT;
        end else if (in_use_dma) begin
          tf.command_code = in_write_req ? OP_WRITE_DMA_EXT : OP_READ_DMA_EXT;
        end else begin
          tf.command_code = in_write_req ? OP_WRITE_SECT_EXT : OP_READ_SECT_EXT;
        end
      end else begin
        tf.layout = in_queued ? LAYOUT_QLBA28 : LAYOUT_LBA28;
        tf.error_code = over_short ? ERR_LENGTH : ERR_OK;
        tf.block_address = {20'h00000, in_start_block[27:0]};
        if (in_queued) begin
          tf.tag_out = in_queue_tag;
          tf.command_code = in_write_req ? OP_WRITE_DMA_Q : OP_READ_DMA_Q;
        end else if (in_use_dma) begin
          tf.command_code = in_write_req ? OP_WRITE_DMA : OP_READ_DMA;
        end else begin
          tf.command_code = in_write_req ? OP_WRITE_SECT : OP_READ_SECT;
        end
      end
    end else begin
      if (over_short) begin
        tf.error_code = ERR_LENGTH;
      end else if (heads_r == '0 || spt_r == '0) begin
        tf.error_code = ERR_TRACK;
      end
      tf.chs_ok = (tf.error_code == ERR_OK);
      if (in_use_dma) begin
        tf.command_code = in_write_req ? OP_WRITE_DMA : OP_READ_DMA;
      end else begin
        tf.command_code = in_write_req ? OP_WRITE_SECT : OP_READ_SECT;
      end
    end
    if (tf.error_code != ERR_OK) begin
      tf.command_code = '0;
      tf.count_out = '0;
      tf.block_address = '0;
      tf.tag_out = '0;
    end
    dec_nxt.tf = tf;
    dec_nxt.spt = spt_r;
  end

  assign track_nxt = TRACK_W'(heads_r) * TRACK_W'(spt_r);
  assign dec_rdy = !dec_v_r || !div1_in_stall;
  assign in_stall = !dec_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
    end else if (dec_rdy) begin
      dec_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_rdy && in_valid) begin
      dec_r <= dec_nxt;
      pos_r <= in_start_block;
      track_r <= track_nxt;
    end
  end

  // cylinder = block / track, offset = block mod track
  logic               div1_out_valid;
  logic               div1_out_stall;
  logic [CYL_W-1:0]   div1_quo;
  logic [TRACK_W-1:0] div1_rem;
  logic [Side1W-1:0]  div1_side;
  side1_t             s1;
  side2_t             s2_in;

  atf_div #(
    .DividendW(POS_W),
    .DivisorW (TRACK_W),
    .QuotW    (CYL_W),
    .SideW    (Side1W),
    .StepBits (StepBits)
  ) u_div_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (dec_v_r),
    .in_stall     (div1_in_stall),
    .in_dividend  (pos_r),
    .in_divisor   (track_r),
    .in_side      (dec_r),
    .out_valid    (div1_out_valid),
    .out_stall    (div1_out_stall),
    .out_quotient (div1_quo),
    .out_remainder(div1_rem),
    .out_side     (div1_side)
  );

  assign s1 = side1_t'(div1_side);
  assign s2_in.tf = s1.tf;
  assign s2_in.cyl = div1_quo;

  // head = offset / spt, sector = offset mod spt + 1
  logic              div2_out_valid;
  logic              div2_out_stall;
  logic [HEAD_W-1:0] div2_quo;
  logic [SPT_W-1:0]  div2_rem;
  logic [Side2W-1:0] div2_side;
  side2_t            s2;

  atf_div #(
    .DividendW(TRACK_W),
    .DivisorW (SPT_W),
    .QuotW    (HEAD_W),
    .SideW    (Side2W),
    .StepBits (StepBits)
  ) u_div_spt (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (div1_out_valid),
    .in_stall     (div1_out_stall),
    .in_dividend  (div1_rem),
    .in_divisor   (s1.spt),
    .in_side      (s2_in),
    .out_valid    (div2_out_valid),
    .out_stall    (div2_out_stall),
    .out_quotient (div2_quo),
    .out_remainder(div2_rem),
    .out_side     (div2_side)
  );

  assign s2 = side2_t'(div2_side);

  // output register
  logic               out_v_r;
  tf_t                out_tf_r;
  logic [CYL_W-1:0]   out_cyl_r;
  logic [HEAD_W-1:0]  out_head_r;
  logic [SEC_W-1:0]   out_sec_r;
  logic               out_rdy;

  assign out_rdy = !out_v_r || !out_stall;
  assign div2_out_stall = !out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= div2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && div2_out_valid) begin
      out_tf_r <= s2.tf;
      if (s2.tf.chs_ok) begin
        out_cyl_r <= s2.cyl;
        out_head_r <= div2_quo;
        out_sec_r <= SEC_W'(div2_rem + 8'd1);
      end else begin
        out_cyl_r <= '0;
        out_head_r <= '0;
        out_sec_r <= '0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_error_code = out_tf_r.error_code;
  assign out_layout = out_tf_r.layout;
  assign out_command_code = out_tf_r.command_code;
  assign out_count_out = out_tf_r.count_out;
  assign out_block_address = out_tf_r.block_address;
  assign out_tag_out = out_tf_r.tag_out;
  assign out_cylinder = out_cyl_r;
  assign out_head = out_head_r;
  assign out_sector = out_sec_r;

endmodule

// ----- rtl/atf_div.sv -----
// Pipelined restoring divider, StepBits quotient bits per stage, with a sideband.
// Per-stage valid and a ready chain let bubbles collapse. Uses atf_pkg constants.
module atf_div #(
  parameter int DividendW = atf_pkg::POS_W,
  parameter int DivisorW = atf_pkg::TRACK_W,
  parameter int QuotW = atf_pkg::CYL_W,
  parameter int SideW = 1,
  parameter int StepBits = atf_pkg::DIV_STEP_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DividendW-1:0] in_dividend,
  input  logic [DivisorW-1:0]  in_divisor,
  input  logic [SideW-1:0]     in_side,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [QuotW-1:0]     out_quotient,
  output logic [DivisorW-1:0]  out_remainder,
  output logic [SideW-1:0]     out_side
);

  localparam int NumStages = (DividendW + StepBits - 1) / StepBits;
  localparam int PadW = NumStages * StepBits;

  logic                v_r    [NumStages];
  logic [DivisorW-1:0] rem_r  [NumStages];
  logic [DivisorW-1:0] dvs_r  [NumStages];
  logic [PadW-1:0]     num_r  [NumStages];
  logic [QuotW-1:0]    quo_r  [NumStages];
  logic [SideW-1:0]    side_r [NumStages];
  logic                rdy    [NumStages];

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    logic                prev_v;
    logic [DivisorW-1:0] prev_rem;
    logic [DivisorW-1:0] prev_dvs;
    logic [PadW-1:0]     prev_num;
    logic [QuotW-1:0]    prev_quo;
    logic [SideW-1:0]    prev_side;
    logic                down_rdy;
    logic [DivisorW-1:0] rem_nxt;
    logic [PadW-1:0]     num_nxt;
    logic [QuotW-1:0]    quo_nxt;

    if (i == 0) begin : g_first
      assign prev_v = in_valid;
      assign prev_rem = '0;
      assign prev_dvs = in_divisor;
      assign prev_num = PadW'(in_dividend);
      assign prev_quo = '0;
      assign prev_side = in_side;
    end else begin : g_next
      assign prev_v = v_r[i-1];
      assign prev_rem = rem_r[i-1];
      assign prev_dvs = dvs_r[i-1];
      assign prev_num = num_r[i-1];
      assign prev_quo = quo_r[i-1];
      assign prev_side = side_r[i-1];
    end

    if (i == NumStages - 1) begin : g_last
      assign down_rdy = !out_stall;
    end else begin : g_mid
      assign down_rdy = rdy[i+1];
    end

    assign rdy[i] = !v_r[i] || down_rdy;

    always_comb begin : p_step
      logic [DivisorW:0] trial;
      rem_nxt = prev_rem;
      num_nxt = prev_num;
      quo_nxt = prev_quo;
      for (int k = 0; k < StepBits; k++) begin
        trial = {rem_nxt, num_nxt[PadW-1]};
        num_nxt = num_nxt << 1;
        if (trial >= {1'b0, prev_dvs}) begin
          rem_nxt = DivisorW'(trial - {1'b0, prev_dvs});
          quo_nxt = {quo_nxt[QuotW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DivisorW-1:0];
          quo_nxt = {quo_nxt[QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && prev_v) begin
        rem_r[i] <= rem_nxt;
        dvs_r[i] <= prev_dvs;
        num_r[i] <= num_nxt;
        quo_r[i] <= quo_nxt;
        side_r[i] <= prev_side;
      end
    end
  end

  assign in_stall = !rdy[0];
  assign out_valid = v_r[NumStages-1];
  assign out_quotient = quo_r[NumStages-1];
  assign out_remainder = rem_r[NumStages-1];
  assign out_side = side_r[NumStages-1];

endmodule

// ----- rtl/atf_checker.sv -----
// Port-level checks on the task-file result channel, bound to the top level.
// Depends on atf_pkg for layout and error codes.
module atf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        out_error_code,
  input logic [2:0]                        out_layout,
  input logic [atf_pkg::CMD_W-1:0]         out_command_code,
  input logic [atf_pkg::COUT_W-1:0]        out_count_out,
  input logic [atf_pkg::POS_W-1:0]         out_block_address,
  input logic [atf_pkg::TAG_W-1:0]         out_tag_out,
  input logic [atf_pkg::CYL_W-1:0]         out_cylinder,
  input logic [atf_pkg::HEAD_W-1:0]        out_head,
  input logic [atf_pkg::SEC_W-1:0]         out_sector
);
  import atf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command_code) &&
      $stable(out_block_address) && $stable(out_cylinder))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_OK |->
      out_command_code == '0 && out_count_out == '0 && out_block_address == '0 &&
      out_tag_out == '0 && out_cylinder == '0 && out_head == '0 &&
      out_sector == '0)
    else $error("error result carries nonzero fields");

  a_chs_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layout == LAYOUT_CHS |->
      out_block_address == '0 && out_tag_out == '0)
    else $error("CHS result carries an address or tag");

  a_lba_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layout != LAYOUT_CHS |->
      out_cylinder == '0 && out_head == '0 && out_sector == '0 &&
      out_error_code != ERR_TRACK)
    else $error("block-addressed result carries CHS fields");

  a_sector_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layout == LAYOUT_CHS && out_error_code == ERR_OK &&
      out_head == '0 && out_cylinder == '0 |-> out_sector != '0 ||
      out_command_code != '0)
    else $error("CHS ok result with no opcode");

endmodule

bind ata_rw_taskfile_builder atf_checker u_atf_checker (.*);

// ----- tb/tb_ata_rw_taskfile_builder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ata_rw_taskfile_builder: directed and random requests
// with random idling on both channels, checked against an in-bench task-file predictor.
// Depends on atf_pkg and the builder RTL.
module tb_ata_rw_taskfile_builder;
  import atf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [POS_W-1:0] start_block;
    logic [CNT_W-1:0] block_count;
    logic write_req;
    logic use_dma;
    logic queued;
    logic [TAG_W-1:0] queue_tag;
  } request_t;

  typedef struct packed {
    err_t error_code;
    layout_t layout;
    logic [CMD_W-1:0] command_code;
    logic [COUT_W-1:0] count_out;
    logic [POS_W-1:0] block_address;
    logic [TAG_W-1:0] tag_out;
    logic [CYL_W-1:0] cylinder;
    logic [HEAD_W-1:0] head;
    logic [SEC_W-1:0] sector;
  } taskfile_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [POS_W-1:0] in_start_block;
  logic [CNT_W-1:0] in_block_count;
  logic in_write_req;
  logic in_use_dma;
  logic in_queued;
  logic [TAG_W-1:0] in_queue_tag;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_error_code;
  logic [2:0] out_layout;
  logic [CMD_W-1:0] out_command_code;
  logic [COUT_W-1:0] out_count_out;
  logic [POS_W-1:0] out_block_address;
  logic [TAG_W-1:0] out_tag_out;
  logic [CYL_W-1:0] out_cylinder;
  logic [HEAD_W-1:0] out_head;
  logic [SEC_W-1:0] out_sector;

  // shadow copy of the block's registers
  logic reg_by_block;
  logic reg_allow_48;
  logic [HEADS_W-1:0] reg_heads;
  logic [SPT_W-1:0] reg_spt;

  taskfile_t pending_taskfiles[$];
  int mismatch_count;
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;

  ata_rw_taskfile_builder dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_block(in_start_block),
    .in_block_count(in_block_count),
    .in_write_req(in_write_req),
    .in_use_dma(in_use_dma),
    .in_queued(in_queued),
    .in_queue_tag(in_queue_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_error_code(out_error_code),
    .out_layout(out_layout),
    .out_command_code(out_command_code),
    .out_count_out(out_count_out),
    .out_block_address(out_block_address),
    .out_tag_out(out_tag_out),
    .out_cylinder(out_cylinder),
    .out_head(out_head),
    .out_sector(out_sector)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [CMD_W-1:0] short_opcode(logic dma, logic wr);
    if (dma) return wr ? OP_WRITE_DMA : OP_READ_DMA;
    return wr ? OP_WRITE_SECT : OP_READ_SECT;
  endfunction

  function automatic taskfile_t predict_taskfile(request_t r);
    taskfile_t t;
    logic [POS_W:0] reach;
    logic [TRACK_W-1:0] track;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] quot;
    logic [POS_W-1:0] hd;
    logic [POS_W-1:0] sec;
    t = '0;
    reach = {1'b0, r.start_block} + {{(POS_W + 1 - CNT_W){1'b0}}, r.block_count};
    if (reg_by_block) begin
      if (reg_allow_48 && (reach > LBA28_LIMIT || r.block_count > SHORT_MAX_COUNT)) begin
        if (r.queued) t.layout = LAYOUT_QLBA48;
        else t.layout = LAYOUT_LBA48;
        if (r.block_count > LONG_MAX_COUNT) begin
          t.error_code = ERR_LENGTH;
        end else begin
          t.count_out = r.block_count[COUT_W-1:0];
          t.block_address = r.start_block;
          if (r.queued) begin
            t.tag_out = r.queue_tag;
            t.command_code = r.write_req ? OP_WRITE_DMA_Q_EXT : OP_READ_DMA_Q_EXT;
          end else if (r.use_dma) begin
            t.command_code = r.write_req ? OP_WRITE_DMA_EXT : OP_READ_DMA_EXT;
          end else begin
            t.command_code = r.write_req ? OP_WRITE_SECT_EXT : OP_READ_SECT_EXT;
          end
        end
      end else begin
        if (r.queued) t.layout = LAYOUT_QLBA28;
        else t.layout = LAYOUT_LBA28;
        if (r.block_count > SHORT_MAX_COUNT) begin
          t.error_code = ERR_LENGTH;
        end else begin
          t.count_out = {8'd0, r.block_count[7:0]};
          t.block_address = {20'd0, r.start_block[27:0]};
          if (r.queued) begin
            t.tag_out = r.queue_tag;
            t.command_code = r.write_req ? OP_WRITE_DMA_Q : OP_READ_DMA_Q;
          end else begin
            t.command_code = short_opcode(r.use_dma, r.write_req);
          end
        end
      end
    end else begin
      t.layout = LAYOUT_CHS;
      track = {{SPT_W{1'b0}}, reg_heads} * {{HEADS_W{1'b0}}, reg_spt};
      if (r.block_count > SHORT_MAX_COUNT) begin
        t.error_code = ERR_LENGTH;
      end else if (track == '0) begin
        t.error_code = ERR_TRACK;
      end else begin
        quot = r.start_block / {{(POS_W - TRACK_W){1'b0}}, track};
        off = r.start_block % {{(POS_W - TRACK_W){1'b0}}, track};
        hd = off / {{(POS_W - SPT_W){1'b0}}, reg_spt};
        sec = (off % {{(POS_W - SPT_W){1'b0}}, reg_spt}) + 48'd1;
        t.count_out = {8'd0, r.block_count[7:0]};
        t.cylinder = quot[CYL_W-1:0];
        t.head = hd[HEAD_W-1:0];
        t.sector = sec[SEC_W-1:0];
        t.command_code = short_opcode(r.use_dma, r.write_req);
      end
    end
    return t;
  endfunction

  function automatic request_t make_request(logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt,
                                            logic wr, logic dma, logic q, logic [TAG_W-1:0] tag);
    request_t r;
    r.start_block = pos;
    r.block_count = cnt;
    r.write_req = wr;
    r.use_dma = dma;
    r.queued = q;
    r.queue_tag = tag;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    case ($urandom_range(0, 4))
      0: r.start_block = 48'($urandom_range(0, 32'hffff));
      1: r.start_block = 48'hfffffff - 48'd600 + 48'($urandom_range(0, 1200));
      2: r.start_block = {16'($urandom), $urandom};
      3: r.start_block = {20'd0, 28'($urandom)};
      default: r.start_block = 48'hffff_ffff_ffff - 48'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 6))
      0, 1: r.block_count = 17'($urandom_range(0, 256));
      2: r.block_count = 17'($urandom_range(254, 258));
      3: r.block_count = 17'($urandom_range(257, 32'hffff));
      4: r.block_count = 17'($urandom_range(32'hfffd, 32'h10002));
      5: r.block_count = 17'($urandom_range(0, 3));
      default: r.block_count = 17'($urandom);
    endcase
    r.write_req = 1'($urandom);
    r.use_dma = 1'($urandom);
    r.queued = 1'($urandom);
    r.queue_tag = 5'($urandom);
    return r;
  endfunction

  // Called just after a rising edge; leaves valid high after the transfer.
  task automatic send_request(input request_t r);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_block <= r.start_block;
    in_block_count <= r.block_count;
    in_write_req <= r.write_req;
    in_use_dma <= r.use_dma;
    in_queued <= r.queued;
    in_queue_tag <= r.queue_tag;
    do @(posedge clk); while (in_stall);
    pending_taskfiles.push_back(predict_taskfile(r));
  endtask

  task automatic random_burst(input int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_taskfiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ADDR_BY_BLOCK: reg_by_block = data[0];
      CFG_ALLOW_48BIT: reg_allow_48 = data[0];
      CFG_HEADS: reg_heads = data[HEADS_W-1:0];
      CFG_SPT: reg_spt = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unused upper data bits carry junk; the block must drop them
  task automatic set_config(input logic by_block, input logic allow48,
                            input logic [HEADS_W-1:0] heads, input logic [SPT_W-1:0] spt);
    drain_results();
    write_reg(CFG_ADDR_BY_BLOCK, {7'($urandom), by_block});
    write_reg(CFG_ALLOW_48BIT, {7'($urandom), allow48});
    write_reg(CFG_HEADS, {3'($urandom), heads});
    write_reg(CFG_SPT, spt);
  endtask

  task automatic test_block_layouts();
    set_config(1'b1, 1'b1, 5'd16, 8'd63);
    send_request(make_request(48'd0, 17'd0, 1'b0, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'd0, 17'h100, 1'b0, 1'b1, 1'b0, 5'd0));
    send_request(make_request(48'd0, 17'h101, 1'b1, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'hfffff00, 17'hff, 1'b1, 1'b1, 1'b0, 5'd0));
    send_request(make_request(48'hfffff00, 17'h100, 1'b0, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'hffff_ffff_ffff, 17'hffff, 1'b0, 1'b1, 1'b0, 5'd0));
    send_request(make_request(48'hffff_ffff_ffff, 17'h10000, 1'b1, 1'b1, 1'b0, 5'd0));
    send_request(make_request(48'h1234_5678_9abc, 17'h1ffff, 1'b0, 1'b0, 1'b1, 5'd31));
    send_request(make_request(48'h8000_0000_0000, 17'd2, 1'b1, 1'b0, 1'b1, 5'd31));
    send_request(make_request(48'h0abcdef, 17'h10, 1'b0, 1'b1, 1'b1, 5'd0));
    send_request(make_request(48'hfffffff, 17'd0, 1'b1, 1'b0, 1'b1, 5'd21));
  endtask

  task automatic test_no_48bit();
    set_config(1'b1, 1'b0, 5'd16, 8'd63);
    send_request(make_request(48'hffff_ffff_ffff, 17'h100, 1'b0, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'd0, 17'h101, 1'b0, 1'b1, 1'b0, 5'd0));
    send_request(make_request(48'h0123_4567_89ab, 17'h80, 1'b1, 1'b1, 1'b1, 5'd10));
  endtask

  task automatic test_chs_translation();
    set_config(1'b0, 1'b1, 5'd16, 8'd63);
    send_request(make_request(48'd0, 17'd0, 1'b0, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'hffff_ffff_ffff, 17'h100, 1'b1, 1'b1, 1'b1, 5'd31));
    send_request(make_request(48'd1007, 17'd1, 1'b0, 1'b1, 1'b0, 5'd0));
    send_request(make_request(48'd12345, 17'h101, 1'b0, 1'b0, 1'b0, 5'd0));
    set_config(1'b0, 1'b0, 5'd31, 8'd255);
    send_request(make_request(48'd7904, 17'd7, 1'b1, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'hffff_ffff_ffff, 17'h100, 1'b0, 1'b0, 1'b1, 5'd3));
    set_config(1'b0, 1'b1, 5'd1, 8'd1);
    send_request(make_request(48'h0000_0012_ffff, 17'd3, 1'b1, 1'b1, 1'b0, 5'd0));
    set_config(1'b0, 1'b1, 5'd0, 8'd63);
    send_request(make_request(48'd5, 17'd1, 1'b0, 1'b0, 1'b0, 5'd0));
    send_request(make_request(48'd5, 17'h101, 1'b0, 1'b0, 1'b0, 5'd0));
    set_config(1'b0, 1'b1, 5'd16, 8'd0);
    send_request(make_request(48'd5, 17'd1, 1'b1, 1'b0, 1'b0, 5'd0));
  endtask

  task automatic test_random_configs();
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: set_config(1'b1, 1'b1, 5'd16, 8'd63);
        1: set_config(1'b1, 1'b0, 5'd16, 8'd63);
        2: set_config(1'b0, 1'b1, 5'd16, 8'd63);
        3: set_config(1'b0, 1'b0, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        4: set_config(1'b0, 1'b1, 5'd1, 8'd1);
        5: set_config(1'b0, 1'b0, 5'd16, 8'd255);
        default: set_config(1'b1, 1'b1, 5'd31, 8'd255);
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      random_burst(105);
    end
  endtask

  // output held off long enough for the pipeline to back up into the input
  task automatic test_output_hold();
    set_config(1'b1, 1'b1, 5'd16, 8'd63);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_req = 1'b1;
    random_burst(60);
  endtask

  task automatic test_sender_pause();
    set_config(1'b0, 1'b1, 5'd15, 8'd17);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    random_burst(20);
    drain_results();
    random_burst(20);
  endtask

  task automatic test_steady_stream();
    set_config(1'b1, 1'b1, 5'd16, 8'd63);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_burst(100);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_start_block = '0;
    in_block_count = '0;
    in_write_req = 1'b0;
    in_use_dma = 1'b0;
    in_queued = 1'b0;
    in_queue_tag = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_req = 1'b0;
    mismatch_count = 0;
    reg_by_block = 1'b1;
    reg_allow_48 = 1'b1;
    reg_heads = HEADS_RESET;
    reg_spt = SPT_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_block_layouts();
    test_no_48bit();
    test_chs_translation();
    test_random_configs();
    test_output_hold();
    test_sender_pause();
    test_steady_stream();
    drain_results();
    if (mismatch_count == 0) begin
      $display("tb_ata_rw_taskfile_builder OK");
    end else begin
      $display("tb_ata_rw_taskfile_builder NOT OK");
    end
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    taskfile_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_taskfiles.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transfer, expected none actual layout %0h",
                   $time, out_layout);
        end else begin
          want = pending_taskfiles.pop_front();
          check_field("error_code", 48'(want.error_code), 48'(out_error_code));
          check_field("layout", 48'(want.layout), 48'(out_layout));
          check_field("command_code", 48'(want.command_code), 48'(out_command_code));
          check_field("count_out", 48'(want.count_out), 48'(out_count_out));
          check_field("block_address", want.block_address, out_block_address);
          check_field("tag_out", 48'(want.tag_out), 48'(out_tag_out));
          check_field("cylinder", 48'(want.cylinder), 48'(out_cylinder));
          check_field("head", 48'(want.head), 48'(out_head));
          check_field("sector", 48'(want.sector), 48'(out_sector));
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_ata_rw_taskfile_builder NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/atf_pkg.sv
rtl/atf_div.sv
rtl/ata_rw_taskfile_builder.sv
rtl/atf_checker.sv
tb/tb_ata_rw_taskfile_builder.sv
